// File: rtl/ikin_pkg.sv
// Shared types, constants and helpers for the two-link arm inverse kinematics unit.
// Used by the CORDIC cell and the top level; depends on nothing.
`default_nettype none
package ikin_pkg;

  // CORDIC datapath width: covers the largest vector (phi) with gain headroom.
  localparam int CW = 50;
  // Angle accumulator width, 2^31 = pi, with room for the pre-rotation.
  localparam int ZW = 33;

  typedef logic signed [CW-1:0] cvec_t;
  typedef logic signed [ZW-1:0] cang_t;

  typedef struct packed {
    cvec_t x;
    cvec_t y;
    cang_t z;
  } rot_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_UPPER  = 2'd0,
    REG_FORE   = 2'd1,
    REG_OFFSET = 2'd2,
    REG_SPARE  = 2'd3
  } reg_idx_t;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  localparam cang_t QUARTER_TURN = 33'sh040000000;

  // Fold a left-half-plane vector into the right half plane.
  function automatic rot_t prerotate(input cvec_t xv, input cvec_t yv);
    rot_t r;
    r.x = xv;
    r.y = yv;
    r.z = '0;
    if (xv < 0) begin
      if (yv >= 0) begin
        r.x = yv;
        r.y = -xv;
        r.z = QUARTER_TURN;
      end else begin
        r.x = -yv;
        r.y = xv;
        r.z = -QUARTER_TURN;
      end
    end
    return r;
  endfunction

  // Round the accumulator to 32768 = pi and keep the low 16 bits.
  function automatic logic signed [15:0] round_angle(input cang_t z);
    cang_t t;
    t = z + 33'sd32768;
    return t[31:16];
  endfunction

endpackage
`default_nettype wire

// File: rtl/ikin_div_cell.sv
// One quotient bit of the pipelined restoring divider.
// Standalone cell; chained in the top level.
`default_nettype none
module ikin_div_cell #(
  parameter int K = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rem_in,
  input  logic [32:0] den_in,
  input  logic [30:0] quo_in,
  output logic [63:0] rem_out,
  output logic [32:0] den_out,
  output logic [30:0] quo_out
);

  logic [63:0] sub;
  logic        ge;

  assign sub = 64'(den_in) << K;
  assign ge  = rem_in >= sub;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= ge ? rem_in - sub : rem_in;
      den_out <= den_in;
      quo_out <= ge ? (quo_in | (31'(1) << K)) : quo_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ikin_sqrt_cell.sv
// One root bit of the pipelined integer square root.
// Standalone cell; chained in the top level.
`default_nettype none
module ikin_sqrt_cell #(
  parameter int K = 0
) (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] rem_in,
  input  logic [30:0] root_in,
  output logic [63:0] rem_out,
  output logic [30:0] root_out
);

  logic [63:0] trial;
  logic        ge;

  // (r + 2^K)^2 - r^2
  assign trial = (64'(root_in) << (K + 1)) + (64'(1) << (2 * K));
  assign ge    = rem_in >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= ge ? rem_in - trial : rem_in;
      root_out <= ge ? (root_in | (31'(1) << K)) : root_in;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ikin_cordic_cell.sv
// One vectoring CORDIC micro-rotation, registered.
// Depends on ikin_pkg for widths and the arctangent table.
`default_nettype none
module ikin_cordic_cell
  import ikin_pkg::*;
#(
  parameter int I = 0
) (
  input  logic  clk,
  input  logic  en,
  input  cvec_t x_in,
  input  cvec_t y_in,
  input  cang_t z_in,
  output cvec_t x_out,
  output cvec_t y_out,
  output cang_t z_out
);

  localparam logic [4:0] IDX = 5'(I);
  localparam cang_t STEP = $signed({1'b0, ATAN_TAB[IDX]});

  cvec_t dx;
  cvec_t dy;

  assign dx = y_in >>> I;
  assign dy = x_in >>> I;

  always_ff @(posedge clk) begin
    if (en) begin
      if (y_in >= 0) begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + STEP;
      end else begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - STEP;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/two_link_arm_inverse_kinematics_unit.sv
// Two-link arm inverse kinematics: fully pipelined, one beat per cycle.
// Throughput: one item per cycle; the whole pipe holds when the output is stalled.
// Reset (rst, synchronous): empties the pipe and loads the default link lengths
// and height offset. Depends on ikin_pkg and the div, sqrt and CORDIC cells.
`default_nettype none
module two_link_arm_inverse_kinematics_unit
  import ikin_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write port
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [17:0] target_x,
  input  logic signed [17:0] target_y,
  input  logic signed [17:0] target_z,
  input  logic signed [15:0] tool_heading,
  // output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] base_height,
  output logic signed [15:0] shoulder_angle,
  output logic signed [15:0] elbow_angle,
  output logic signed [17:0] wrist_angle,
  output logic               unreachable
);

  localparam int NI = CORDIC_ITERATIONS;

  // Stage numbering (register stage k is the k-th register an item passes after acceptance).
  localparam int S_MUL = 1;   // squares and link product
  localparam int S_ND  = 2;   // n and d
  localparam int S_NUM = 3;   // |n|, reach test, dividend
  localparam int S_C   = 35;  // signed cosine after 31 divider cells
  localparam int S_CC  = 36;  // cosine squared
  localparam int S_V   = 37;  // 2^60 - c^2
  localparam int S_PR  = 69;  // link products after 31 root cells
  localparam int S_VEC = 70;  // CORDIC input vectors
  localparam int S_ROT = 71;  // half-plane fold
  localparam int S_RND = S_ROT + NI + 1;
  localparam int L     = S_RND + 1;

  typedef struct packed {
    logic signed [18:0] base;
    logic signed [15:0] hd;
    logic               unr;
    logic               neg;
    logic signed [17:0] x;
    logic signed [17:0] y;
    logic signed [31:0] c;
    logic               ze;
    logic               zp;
    logic               zb;
  } side_t;

  // ---------------------------------------------------------------------
  // Configuration registers. The user must write them only while the pipe is
  // empty, so the stages read them directly; the block does not enforce this.
  // ---------------------------------------------------------------------
  logic [15:0]        upper_arm_length;
  logic [15:0]        forearm_length;
  logic signed [16:0] height_offset;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_arm_length <= 16'd10240;
      forearm_length   <= 16'd10854;
      height_offset    <= 17'sd11264;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_UPPER:  upper_arm_length <= cfg_data[15:0];
        REG_FORE:   forearm_length   <= cfg_data[15:0];
        REG_OFFSET: height_offset    <= $signed(cfg_data);
        REG_SPARE: ;  // unused index: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Flow control: one global advance. Hold everything while a finished
  // result waits on a stalled output.
  // ---------------------------------------------------------------------
  logic         adv;
  logic [L-1:0] vld;

  assign adv      = !(vld[L-1] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[L-2:0], in_valid};
    end
  end

  // ---------------------------------------------------------------------
  // Sideband line: items that ride along with the arithmetic.
  // ---------------------------------------------------------------------
  side_t sb   [1:L-1];
  side_t sb_d [1:L-1];

  // Datapath registers of the non-cell stages.
  logic [34:0]        xx;
  logic [34:0]        yy;
  logic [31:0]        l1sq;
  logic [31:0]        l2sq;
  logic [31:0]        l1l2;
  logic signed [37:0] n_r;
  logic [32:0]        d_r;
  logic [63:0]        num_r;
  logic [32:0]        den_r;
  logic [60:0]        cc_r;
  logic [63:0]        v_r;
  logic [30:0]        s_pr;
  logic [46:0]        ps_r;
  logic signed [47:0] pc_r;
  cvec_t              vex, vey, vpx, vpy, vbx, vby;
  rot_t               rot_e, rot_p, rot_b;
  logic signed [15:0] su_r, eu_r, sd_r, ed_r;

  // Stage 3 combinational terms.
  logic [36:0]        an;
  logic               unr_d;
  logic [63:0]        num_d;

  assign an    = n_r[37] ? 37'(-n_r) : 37'(n_r);
  assign unr_d = (d_r == '0) || (an > 37'(d_r));
  assign num_d = (64'(an) << 30) + 64'(d_r >> 1);

  // Divider chain: quotient bits 30 down to 0.
  logic [63:0] drem [0:31];
  logic [32:0] dden [0:31];
  logic [30:0] dquo [0:31];

  assign drem[0] = num_r;
  assign dden[0] = den_r;
  assign dquo[0] = '0;

  for (genvar j = 0; j < 31; j++) begin : g_div
    ikin_div_cell #(.K(30 - j)) u_div (
      .clk     (clk),
      .en      (adv),
      .rem_in  (drem[j]),
      .den_in  (dden[j]),
      .quo_in  (dquo[j]),
      .rem_out (drem[j+1]),
      .den_out (dden[j+1]),
      .quo_out (dquo[j+1])
    );
  end

  // Square root chain: root bits 30 down to 0.
  logic [63:0] qrem  [0:31];
  logic [30:0] qroot [0:31];

  assign qrem[0]  = v_r;
  assign qroot[0] = '0;

  for (genvar j = 0; j < 31; j++) begin : g_sqrt
    ikin_sqrt_cell #(.K(30 - j)) u_sqrt (
      .clk      (clk),
      .en       (adv),
      .rem_in   (qrem[j]),
      .root_in  (qroot[j]),
      .rem_out  (qrem[j+1]),
      .root_out (qroot[j+1])
    );
  end

  // Three CORDIC chains: elbow angle e, offset angle phi, bearing b.
  cvec_t ex [0:NI];
  cvec_t ey [0:NI];
  cang_t ez [0:NI];
  cvec_t px [0:NI];
  cvec_t py [0:NI];
  cang_t pz [0:NI];
  cvec_t bx [0:NI];
  cvec_t by [0:NI];
  cang_t bz [0:NI];

  assign ex[0] = rot_e.x;
  assign ey[0] = rot_e.y;
  assign ez[0] = rot_e.z;
  assign px[0] = rot_p.x;
  assign py[0] = rot_p.y;
  assign pz[0] = rot_p.z;
  assign bx[0] = rot_b.x;
  assign by[0] = rot_b.y;
  assign bz[0] = rot_b.z;

  for (genvar j = 0; j < NI; j++) begin : g_cordic
    ikin_cordic_cell #(.I(j)) u_e (
      .clk (clk), .en (adv),
      .x_in (ex[j]), .y_in (ey[j]), .z_in (ez[j]),
      .x_out (ex[j+1]), .y_out (ey[j+1]), .z_out (ez[j+1])
    );
    ikin_cordic_cell #(.I(j)) u_p (
      .clk (clk), .en (adv),
      .x_in (px[j]), .y_in (py[j]), .z_in (pz[j]),
      .x_out (px[j+1]), .y_out (py[j+1]), .z_out (pz[j+1])
    );
    ikin_cordic_cell #(.I(j)) u_b (
      .clk (clk), .en (adv),
      .x_in (bx[j]), .y_in (by[j]), .z_in (bz[j]),
      .x_out (bx[j+1]), .y_out (by[j+1]), .z_out (bz[j+1])
    );
  end

  // Sideband next values: shift, then patch the stages that add fields.
  always_comb begin
    for (int k = 2; k < L; k++) begin
      sb_d[k] = sb[k-1];
    end
    sb_d[S_MUL].base = 19'(target_z) + 19'(height_offset);
    sb_d[S_MUL].hd   = tool_heading;
    sb_d[S_MUL].unr  = 1'b0;
    sb_d[S_MUL].neg  = 1'b0;
    sb_d[S_MUL].x    = target_x;
    sb_d[S_MUL].y    = target_y;
    sb_d[S_MUL].c    = '0;
    sb_d[S_MUL].ze   = 1'b0;
    sb_d[S_MUL].zp   = 1'b0;
    sb_d[S_MUL].zb   = 1'b0;
    sb_d[S_NUM].unr  = unr_d;
    sb_d[S_NUM].neg  = n_r[37];
    sb_d[S_C].c      = sb[S_C-1].neg ? -$signed({1'b0, dquo[31]})
                                     : $signed({1'b0, dquo[31]});
    sb_d[S_VEC].ze   = (s_pr == '0) && (sb[S_PR].c == '0);
    sb_d[S_VEC].zp   = (ps_r == '0) &&
                       ((49'(upper_arm_length) << 30) + 49'(pc_r) == '0);
    sb_d[S_VEC].zb   = (sb[S_PR].x == '0) && (sb[S_PR].y == '0);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 1; k < L; k++) begin
        sb[k] <= sb_d[k];
      end
    end
  end

  // Arithmetic stages around the cell chains.
  always_ff @(posedge clk) begin
    if (adv) begin
      // squares and link product
      xx   <= 35'(target_x) * 35'(target_x);
      yy   <= 35'(target_y) * 35'(target_y);
      l1sq <= upper_arm_length * upper_arm_length;
      l2sq <= forearm_length * forearm_length;
      l1l2 <= upper_arm_length * forearm_length;
      // n = x^2 + y^2 - L1^2 - L2^2, d = 2 L1 L2
      n_r  <= $signed(38'(xx) + 38'(yy) - 38'(l1sq) - 38'(l2sq));
      d_r  <= {l1l2, 1'b0};
      // rounded dividend
      num_r <= num_d;
      den_r <= d_r;
      // c^2 and the radicand
      cc_r <= 61'(sb[S_C].c) * 61'(sb[S_C].c);
      v_r  <= 64'((61'(1) << 60) - cc_r);
      // link products for phi
      s_pr <= qroot[31];
      ps_r <= forearm_length * qroot[31];
      pc_r <= 48'($signed({1'b0, forearm_length})) * 48'(sb[S_PR-1].c);
      // vectors
      vex <= CW'(s_pr);
      vey <= CW'(sb[S_PR].c);
      vpx <= CW'(ps_r);
      vpy <= CW'($signed((49'(upper_arm_length) << 30) + 49'(pc_r)));
      vbx <= CW'(sb[S_PR].y) <<< 20;
      vby <= CW'(sb[S_PR].x) <<< 20;
      // fold into the right half plane (vectors are y then x)
      rot_e <= prerotate(vey, vex);
      rot_p <= prerotate(vpy, vpx);
      rot_b <= prerotate(vby, vbx);
    end
  end

  // Round the three angles and form both elbow solutions.
  logic signed [15:0] e16, p16, b16;

  assign e16 = sb[S_RND-1].ze ? 16'sd0 : round_angle(ez[NI]);
  assign p16 = sb[S_RND-1].zp ? 16'sd0 : round_angle(pz[NI]);
  assign b16 = sb[S_RND-1].zb ? 16'sd0 : round_angle(bz[NI]);

  always_ff @(posedge clk) begin
    if (adv) begin
      su_r <= b16 - p16;
      eu_r <= e16;
      sd_r <= b16 + p16;
      ed_r <= -e16;
    end
  end

  // Pick the solution with the smaller |shoulder| + |elbow|; up wins ties.
  logic [16:0] asu, aeu, asd, aed;
  logic        pick_down;
  logic signed [15:0] sh_sel, el_sel;

  assign asu = su_r[15] ? 17'(-{su_r[15], su_r}) : 17'(su_r);
  assign aeu = eu_r[15] ? 17'(-{eu_r[15], eu_r}) : 17'(eu_r);
  assign asd = sd_r[15] ? 17'(-{sd_r[15], sd_r}) : 17'(sd_r);
  assign aed = ed_r[15] ? 17'(-{ed_r[15], ed_r}) : 17'(ed_r);
  assign pick_down = (18'(asd) + 18'(aed)) < (18'(asu) + 18'(aeu));
  assign sh_sel    = pick_down ? sd_r : su_r;
  assign el_sel    = pick_down ? ed_r : eu_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      base_height <= sb[L-1].base;
      unreachable <= sb[L-1].unr;
      if (sb[L-1].unr) begin
        shoulder_angle <= '0;
        elbow_angle    <= '0;
        wrist_angle    <= '0;
      end else begin
        shoulder_angle <= sh_sel;
        elbow_angle    <= el_sel;
        wrist_angle    <= 18'(sh_sel) + 18'(el_sel) - 18'(sb[L-1].hd);
      end
    end
  end

  assign out_valid = vld[L-1];

endmodule
`default_nettype wire

// File: tb/two_link_arm_inverse_kinematics_unit_test.sv
// Self-checking testbench for the two-link arm inverse kinematics unit.
// Depends on ikin_pkg and two_link_arm_inverse_kinematics_unit; reads no files.
`timescale 1ns / 1ps
module two_link_arm_inverse_kinematics_unit_test;
  import ikin_pkg::*;

  localparam int STEPS        = 16;    // CORDIC steps of the instance
  localparam int SETTLE       = 120;   // pipe depth plus margin
  localparam int IDLE_LIMIT   = 4000;  // cycles without any beat before giving up
  localparam int RANDOM_ITEMS = 700;

  // One expected result beat.
  typedef struct {
    logic signed [18:0] base;
    logic signed [15:0] shoulder;
    logic signed [15:0] elbow;
    logic signed [17:0] wrist;
    logic               unreach;
  } joint_set_t;

  // Joint predictor plus the queue of joint sets still owed by the block.
  class ik_scoreboard;
    longint     upper_len, fore_len, height_off;
    joint_set_t owed[$];
    int         errors, matched, unreach_seen;

    function new();
      upper_len  = 10240;
      fore_len   = 10854;
      height_off = 11264;
    endfunction

    function void set_reg(logic [1:0] idx, logic [16:0] v);
      case (idx)
        REG_UPPER:  upper_len = v[15:0];
        REG_FORE:   fore_len = v[15:0];
        REG_OFFSET: height_off = longint'($signed(v));
        default: ;
      endcase
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint wrap16(longint v);
      logic signed [15:0] t;
      t = v[15:0];
      return t;
    endfunction

    function bit [63:0] isqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    // Vectoring CORDIC; accumulator 2^31 = pi, result rounded to 32768 = pi.
    function longint atan_q15(longint yv, longint xv);
      longint x, y, z, dx, dy;
      x = xv;
      y = yv;
      z = 0;
      if (xv == 0 && yv == 0) return 0;
      if (xv < 0) begin
        if (yv >= 0) begin
          x = yv; y = -xv; z = 64'sh40000000;
        end else begin
          x = -yv; y = xv; z = -64'sh40000000;
        end
      end
      for (int i = 0; i < STEPS; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += longint'(ATAN_TAB[i]);
        end else begin
          x -= dx; y += dy; z -= longint'(ATAN_TAB[i]);
        end
      end
      return (z + 32768) >>> 16;
    endfunction

    function void note_target(logic signed [17:0] tx, logic signed [17:0] ty,
                              logic signed [17:0] tz, logic signed [15:0] hd);
      longint x, y, n, d, c, s, e, phi, b, su, eu, sd, ed, sh, el;
      bit [63:0] q;
      joint_set_t j;
      x = tx;
      y = ty;
      n = x * x + y * y - upper_len * upper_len - fore_len * fore_len;
      d = 2 * upper_len * fore_len;
      j.base = 19'(longint'(tz) + height_off);
      j.shoulder = '0;
      j.elbow = '0;
      j.wrist = '0;
      j.unreach = 1'b0;
      if (d == 0 || mag(n) > d) begin
        j.unreach = 1'b1;
      end else begin
        q = ((64'(mag(n)) << 30) + 64'(d / 2)) / 64'(d);
        c = n < 0 ? -longint'(q) : longint'(q);
        s = longint'(isqrt((64'd1 << 60) - 64'(c * c)));
        e = atan_q15(s, c);
        phi = atan_q15(fore_len * s, upper_len * (64'sd1 <<< 30) + fore_len * c);
        b = atan_q15(y * (64'sd1 <<< 20), x * (64'sd1 <<< 20));
        su = wrap16(b - phi);
        eu = wrap16(e);
        sd = wrap16(b + phi);
        ed = wrap16(-e);
        // Keep elbow-down only when strictly cheaper.
        if (mag(sd) + mag(ed) < mag(su) + mag(eu)) begin
          sh = sd; el = ed;
        end else begin
          sh = su; el = eu;
        end
        j.shoulder = 16'(sh);
        j.elbow = 16'(el);
        j.wrist = 18'(sh + el - longint'(hd));
      end
      owed.push_back(j);
    endfunction

    task report(string what, longint got, longint want);
      $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
      errors++;
    endtask

    task check_joints(joint_set_t g);
      joint_set_t w;
      if (owed.size() == 0) begin
        report("unexpected beat (base_height)", g.base, 0);
        return;
      end
      w = owed.pop_front();
      if (g.base !== w.base) report("base_height", g.base, w.base);
      if (g.shoulder !== w.shoulder) report("shoulder_angle", g.shoulder, w.shoulder);
      if (g.elbow !== w.elbow) report("elbow_angle", g.elbow, w.elbow);
      if (g.wrist !== w.wrist) report("wrist_angle", g.wrist, w.wrist);
      if (g.unreach !== w.unreach) report("unreachable", g.unreach, w.unreach);
      matched++;
      if (w.unreach) unreach_seen++;
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [16:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [17:0] target_x = '0;
  logic signed [17:0] target_y = '0;
  logic signed [17:0] target_z = '0;
  logic signed [15:0] tool_heading = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [18:0] base_height;
  logic signed [15:0] shoulder_angle;
  logic signed [15:0] elbow_angle;
  logic signed [17:0] wrist_angle;
  logic               unreachable;

  ik_scoreboard sb = new();
  bit           calm = 1'b0;   // no idling on either side in the closing stretch
  int           idle_cycles = 0;
  int           sent = 0;

  two_link_arm_inverse_kinematics_unit #(.CORDIC_ITERATIONS(STEPS)) u_dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .target_x(target_x), .target_y(target_y), .target_z(target_z),
    .tool_heading(tool_heading),
    .out_valid(out_valid), .out_stall(out_stall),
    .base_height(base_height), .shoulder_angle(shoulder_angle),
    .elbow_angle(elbow_angle), .wrist_angle(wrist_angle), .unreachable(unreachable)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Sample both channels at the rising edge; predict on input beats, check on output beats.
  always @(posedge clk) begin
    joint_set_t g;
    if (!rst && in_valid && !in_stall) sb.note_target(target_x, target_y, target_z, tool_heading);
    if (!rst && out_valid && !out_stall) begin
      g.base = base_height;
      g.shoulder = shoulder_angle;
      g.elbow = elbow_angle;
      g.wrist = wrist_angle;
      g.unreach = unreachable;
      sb.check_joints(g);
    end
  end

  // Watchdog: any beat on either side resets the count.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver back-pressure in random bursts, off in the closing stretch.
  always begin
    @(negedge clk);
    if (!calm && !rst && $urandom_range(0, 7) == 0) begin
      out_stall = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
      out_stall = 1'b0;
    end
  end

  task write_reg(logic [1:0] idx, logic [16:0] v);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = v;
    sb.set_reg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drop valid, then hold off until every owed result is back and the pipe has emptied.
  task drain_pipe();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task send_target(int x, int y, int z, int h);
    @(negedge clk);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid = 1'b1;
    target_x = 18'(x);
    target_y = 18'(y);
    target_z = 18'(z);
    tool_heading = 16'(h);
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task end_burst();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  function int clip18(int v);
    if (v > 131071) return 131071;
    if (v < -131072) return -131072;
    return v;
  endfunction

  // Mostly targets in the square of half-side L1 + L2 around the base, the rest over the full field range.
  task random_targets(int count);
    int r, x, y;
    repeat (count) begin
      r = int'(sb.upper_len + sb.fore_len);
      if ($urandom_range(0, 3) == 0 || r == 0) begin
        x = $signed(18'($urandom));
        y = $signed(18'($urandom));
      end else begin
        x = clip18($urandom_range(0, 2 * r) - r);
        y = clip18($urandom_range(0, 2 * r) - r);
      end
      send_target(x, y, $signed(18'($urandom)), $signed(16'($urandom)));
    end
  endtask

  task arm_setup(int l1, int l2, int off);
    drain_pipe();
    write_reg(REG_UPPER, 17'(l1));
    write_reg(REG_FORE, 17'(l2));
    write_reg(REG_OFFSET, 17'(off));
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: reset lengths, field extremes, full stretch, far corner.
    send_target(0, 0, 0, 0);
    send_target(21094, 0, 131071, 32767);
    send_target(0, 21094, -131072, -32768);
    send_target(-21094, 0, 5, 1);
    send_target(-10000, -8000, 0, 12345);
    send_target(131071, 131071, 131071, 32767);
    send_target(-131072, -131072, -131072, -32768);
    send_target(-5000, 9000, 1000, -1000);
    end_burst();

    // Equal links: the origin folds the arm fully.
    arm_setup(4096, 4096, -65536);
    send_target(0, 0, -131072, 0);
    send_target(8192, 0, 131071, 0);
    send_target(0, -8192, 0, -32768);
    send_target(-3000, 2000, 17, 32767);
    // A write to the spare index must change nothing.
    end_burst();
    drain_pipe();
    write_reg(REG_SPARE, 17'h1FFFF);
    send_target(1000, 1000, 0, 0);

    // Zero link length: everything is out of reach.
    arm_setup(0, 5000, 65535);
    send_target(5000, 0, 131071, 1);
    send_target(0, 0, -131072, 2);
    arm_setup(5000, 0, 0);
    send_target(5000, 0, 3, 3);

    // Minimum and maximum link lengths.
    arm_setup(1, 1, -65536);
    send_target(1, 1, 0, 0);
    send_target(2, 0, 0, 0);
    send_target(0, 0, 0, 0);
    arm_setup(65535, 65535, 65535);
    send_target(131071, 0, 131071, 32767);
    send_target(-131072, 0, -131072, -32768);
    send_target(0, 0, 0, 0);
    end_burst();

    // Random phases over several arm geometries.
    arm_setup(10240, 10854, 11264);
    random_targets(200);
    end_burst();
    arm_setup(65535, 1, -65536);
    random_targets(80);
    end_burst();
    arm_setup(1, 65535, 65535);
    random_targets(80);
    end_burst();
    arm_setup($urandom_range(1, 65535), $urandom_range(1, 65535), $urandom_range(0, 131071) - 65536);
    random_targets(160);
    end_burst();
    arm_setup($urandom_range(100, 40000), $urandom_range(100, 40000), $urandom_range(0, 131071) - 65536);
    calm = 1'b1;
    random_targets(180);
    end_burst();

    drain_pipe();
    $display("Sent %0d targets over eleven arm setups; checked %0d joint sets, %0d out of reach.",
             sent, sb.matched, sb.unreach_seen);
    $display("Mismatches: %0d", sb.errors);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
